>>> rtl/core/piecewise_linear_table_interpolation_defines.svh
// Assertion macros shared by the piecewise linear interpolation RTL.
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATION_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pwl_pkg.sv
// Shared types and default parameters for the piecewise linear interpolator.
package pwl_pkg;

  // Default configuration
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_DATA_WIDTH  = 16;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_FEW  = 2'd2,
    STATUS_SPAN = 2'd3
  } status_t;

endpackage

>>> rtl/core/piecewise_linear_table_interpolation.sv
// Piecewise linear interpolation over a breakpoint table held in one RAM.
// A breakpoint write is taken while idle; the block stays idle for the next item.
// Query: entries are scanned from entry zero, the span is set up, the product is
// formed and divided bit by bit; the result waits in finish while an earlier result
// stalls the output. Items are taken only in idle. Cost: RAM scan and divider.
// Synchronous reset clears control and point_count; table contents stay undefined.
`include "piecewise_linear_table_interpolation_defines.svh"

module piecewise_linear_table_interpolation #(
  parameter int TABLE_DEPTH = pwl_pkg::DEF_TABLE_DEPTH,
  parameter int DATA_WIDTH  = pwl_pkg::DEF_DATA_WIDTH,
  localparam int IW  = $clog2(TABLE_DEPTH),
  localparam int PCW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [PCW-1:0]        cfg_wr_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [IW-1:0]         point_index,
  input  logic [DATA_WIDTH-1:0] point_x,
  input  logic [DATA_WIDTH-1:0] point_y,
  input  logic [DATA_WIDTH-1:0] query_x,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] value,
  output logic [1:0]            status
);

  localparam int DW   = DATA_WIDTH;
  localparam int QW   = 2 * DW;                 // product / quotient width
  localparam int RW   = DW + 1;                 // divider remainder width
  localparam int CNTW = $clog2(QW);
  localparam int CW   = (QW > 41) ? QW : 41;    // width for the overflow guard
  localparam int SW   = CW + 2;                 // final sum width
  localparam logic [CW-1:0] SAT_LIMIT = CW'(1) << 40;
  localparam logic [DW-1:0] HI_DW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] LO_DW = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FETCH_B, S_SETUP, S_MULT, S_DIVIDE, S_FINISH
  } state_t;

  state_t               st;
  logic [PCW-1:0]       point_count;
  logic [PCW-1:0]       n;
  logic [IW-1:0]        idx;
  logic [DW-1:0]        q;
  logic [DW-1:0]        ax, ay, bx, by;
  logic [RW-1:0]        dmag;
  logic [DW:0]          dy_mag, dq_mag;
  logic                 neg;
  logic [QW-1:0]        quo;
  logic [RW-1:0]        rem;
  logic [CNTW-1:0]      cnt;
  logic                 err;
  pwl_pkg::status_t     err_code;

  // RAM interface
  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [2*DW-1:0]      ram_rdata;
  logic [DW-1:0]        cur_x, cur_y;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  assign in_ready = (st == S_IDLE);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Effective count, clamped to the table depth
  logic [PCW-1:0] n_eff;
  assign n_eff = (point_count > PCW'(TABLE_DEPTH)) ? PCW'(TABLE_DEPTH) : point_count;

  assign ram_we = in_xfer && !mode &&
                  ({1'b0, point_index} < (IW+1)'(TABLE_DEPTH));
  // Scan reads one entry ahead; idle presets entry zero
  assign ram_raddr = (st == S_SCAN) ? idx + IW'(1) : '0;

  pwl_ram #(
    .WIDTH (2 * DW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_index),
    .wdata ({point_x, point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_x = ram_rdata[2*DW-1:DW];
  assign cur_y = ram_rdata[DW-1:0];

  // Scan compare
  logic scan_lt, scan_last;
  assign scan_lt   = $signed(cur_x) < $signed(q);
  assign scan_last = (PCW'(idx) + PCW'(1)) == n;

  // Differences of the chosen span
  logic signed [DW:0] dx_s, dy_s, dq_s;
  assign dx_s = $signed({bx[DW-1], bx}) - $signed({ax[DW-1], ax});
  assign dy_s = $signed({by[DW-1], by}) - $signed({ay[DW-1], ay});
  assign dq_s = $signed({q[DW-1], q})   - $signed({ax[DW-1], ax});

  logic [DW:0] dx_mag_c, dy_mag_c, dq_mag_c;
  assign dx_mag_c = dx_s[DW] ? (DW+1)'(0) - dx_s : dx_s;
  assign dy_mag_c = dy_s[DW] ? (DW+1)'(0) - dy_s : dy_s;
  assign dq_mag_c = dq_s[DW] ? (DW+1)'(0) - dq_s : dq_s;

  // Product of magnitudes; both are below 2**DW, so it fits in QW bits
  logic [QW-1:0] prod;
  assign prod = QW'(dy_mag) * QW'(dq_mag);

  // Restoring divider step
  logic [RW-1:0] rem_sh, rem_sub;
  logic          div_ge;
  assign rem_sh  = {rem[RW-2:0], quo[QW-1]};
  assign div_ge  = rem_sh >= dmag;
  assign rem_sub = rem_sh - dmag;

  // Signed sum and saturation
  logic [CW-1:0]        quot_ext;
  logic                 quot_big;
  logic signed [SW-1:0] ay_ext, q_term, sum, hi_ext, lo_ext;
  assign quot_ext = CW'(quo);
  assign quot_big = quot_ext > SAT_LIMIT;
  assign ay_ext   = SW'($signed(ay));
  assign q_term   = neg ? -$signed({2'b00, quot_ext}) : $signed({2'b00, quot_ext});
  assign sum      = ay_ext + q_term;
  assign hi_ext   = SW'($signed(HI_DW));
  assign lo_ext   = SW'($signed(LO_DW));

  logic [DW-1:0]    fin_value;
  pwl_pkg::status_t fin_status;
  always_comb begin
    fin_value  = sum[DW-1:0];
    fin_status = pwl_pkg::STATUS_OK;
    if (err) begin
      fin_value  = '0;
      fin_status = err_code;
    end else if (quot_big) begin
      fin_value  = neg ? LO_DW : HI_DW;
      fin_status = pwl_pkg::STATUS_SAT;
    end else if (sum > hi_ext) begin
      fin_value  = HI_DW;
      fin_status = pwl_pkg::STATUS_SAT;
    end else if (sum < lo_ext) begin
      fin_value  = LO_DW;
      fin_status = pwl_pkg::STATUS_SAT;
    end
  end

  // Finished result moves into the output register
  logic res_load;
  assign res_load = (st == S_FINISH) && (!out_valid || out_ready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_xfer && mode) begin
            q   <= query_x;
            n   <= n_eff;
            idx <= '0;
            err <= 1'b0;
            if (n_eff < PCW'(2)) begin
              err      <= 1'b1;
              err_code <= pwl_pkg::STATUS_FEW;
              st       <= S_FINISH;
            end else begin
              st <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_lt && !scan_last) begin
            idx <= idx + IW'(1);
            ax  <= cur_x;
            ay  <= cur_y;
          end else if (!scan_lt && (idx == '0)) begin
            ax <= cur_x;
            ay <= cur_y;
            st <= S_FETCH_B;
          end else begin
            bx <= cur_x;
            by <= cur_y;
            st <= S_SETUP;
          end
        end
        S_FETCH_B: begin
          bx <= cur_x;
          by <= cur_y;
          st <= S_SETUP;
        end
        S_SETUP: begin
          dmag   <= dx_mag_c;
          dy_mag <= dy_mag_c;
          dq_mag <= dq_mag_c;
          neg    <= dy_s[DW] ^ dq_s[DW] ^ dx_s[DW];
          if (dx_s == '0) begin
            err      <= 1'b1;
            err_code <= pwl_pkg::STATUS_SPAN;
            st       <= S_FINISH;
          end else begin
            st <= S_MULT;
          end
        end
        S_MULT: begin
          quo <= prod;
          rem <= '0;
          cnt <= CNTW'(QW - 1);
          st  <= S_DIVIDE;
        end
        S_DIVIDE: begin
          rem <= div_ge ? rem_sub : rem_sh;
          quo <= {quo[QW-2:0], div_ge};
          if (cnt == '0) begin
            st <= S_FINISH;
          end else begin
            cnt <= cnt - CNTW'(1);
          end
        end
        S_FINISH: begin
          if (res_load) begin
            value  <= fin_value;
            status <= fin_status;
            st     <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PWL_ASSERT_NEXT(a_query_scans, clk, rst,
    in_xfer && mode && (n_eff >= PCW'(2)), st == S_SCAN, "query with two points did not scan")
  `PWL_ASSERT_SAME(a_scan_in_range, clk, rst,
    st == S_SCAN, PCW'(idx) < n, "scan index beyond point count")
  `PWL_ASSERT_SAME(a_div_nonzero, clk, rst,
    st == S_DIVIDE, dmag != '0, "divider running with zero divisor")
  `PWL_ASSERT_SAME(a_rem_below_div, clk, rst,
    st == S_DIVIDE, rem < dmag, "divider remainder not below divisor")
  `PWL_ASSERT_NEXT(a_finish_loads, clk, rst,
    (st == S_FINISH) && !out_valid, out_valid, "finished result not loaded")

endmodule

>>> rtl/core/pwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
